// File: rtl/hnm_pkg.sv
// Shared types and constants for the heightmap to normal map block.
package hnm_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int SMP_W      = 16;
  localparam int GEO_W      = 13;
  localparam int GAIN_W     = 16;
  localparam int MAG_W      = 32;
  localparam int PROD_W     = 64;
  localparam int RAD_W      = 66;
  localparam int ROOT_W     = 33;
  localparam int REM_W      = 36;
  localparam int NUM_W      = 34;
  localparam int DVD_W      = 42;
  localparam int QUO_W      = 9;
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 9;

  // (2*maxval)^2 for 8 and 16 bit samples
  localparam logic [RAD_W-1:0] CSQ_NARROW = 66'd260100;
  localparam logic [RAD_W-1:0] CSQ_WIDE   = 66'd17179344900;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_GAIN   = 2'd2;
  localparam logic [1:0] REG_WIDE   = 2'd3;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  localparam logic SEL_X = 1'b0;
  localparam logic SEL_Y = 1'b1;

  typedef enum logic [1:0] {NB_LEFT, NB_RIGHT, NB_UP, NB_DOWN} nb_t;

  typedef struct packed {
    logic              cmd;
    logic [SMP_W-1:0]  sample;
  } in_t;

  typedef struct packed {
    logic [7:0] normal_x;
    logic [7:0] normal_y;
    logic       last_pixel;
  } out_t;

  typedef struct packed {
    logic [GEO_W-1:0]  image_width;
    logic [GEO_W-1:0]  image_height;
    logic [GAIN_W-1:0] height_gain;
    logic              wide_samples;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic check;
    logic store;
    logic test;
    logic rd_en;
    nb_t  rd_sel;
    logic cap_en;
    nb_t  cap_sel;
    logic mag;
    logic mul_a;
    logic mul_b;
    logic sq_a;
    logic sq_b;
    logic acc;
    logic sqrt_step;
    logic div_start;
    logic div_sel;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/hnm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hnm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8194
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/hnm_ctrl.sv
// Sequencing state machine for the normal map datapath.
module hnm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hnm_pkg::dp_stat_t  st,
  output hnm_pkg::dp_cmd_t   cmd
);
  import hnm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_STORE, S_TEST, S_RD_L, S_RD_R, S_RD_U, S_RD_D, S_CAP_D,
    S_MAG, S_MUL_A, S_MUL_B, S_SQ_A, S_SQ_B, S_ACC, S_SQRT, S_DIV_X0, S_DIV_X,
    S_DIV_Y0, S_DIV_Y, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          state_nxt    = S_CHECK;
          in_ready_nxt = 1'b0;
        end
      end
      S_CHECK:  state_nxt = S_STORE;
      S_STORE:  state_nxt = S_TEST;
      S_TEST: begin
        if (st.emit_ok) begin
          state_nxt = S_RD_L;
        end else begin
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      S_RD_L:   state_nxt = S_RD_R;
      S_RD_R:   state_nxt = S_RD_U;
      S_RD_U:   state_nxt = S_RD_D;
      S_RD_D:   state_nxt = S_CAP_D;
      S_CAP_D:  state_nxt = S_MAG;
      S_MAG:    state_nxt = S_MUL_A;
      S_MUL_A:  state_nxt = S_MUL_B;
      S_MUL_B:  state_nxt = S_SQ_A;
      S_SQ_A:   state_nxt = S_SQ_B;
      S_SQ_B:   state_nxt = S_ACC;
      S_ACC:    state_nxt = S_SQRT;
      S_SQRT: begin
        if (st.sqrt_done) state_nxt = S_DIV_X0;
      end
      S_DIV_X0: state_nxt = S_DIV_X;
      S_DIV_X: begin
        if (st.div_done) state_nxt = S_DIV_Y0;
      end
      S_DIV_Y0: state_nxt = S_DIV_Y;
      S_DIV_Y: begin
        if (st.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = NB_LEFT;
    cmd.cap_sel = NB_LEFT;
    cmd.div_sel = SEL_X;
    unique case (state_r)
      S_IDLE:  cmd.capture = in_valid && in_ready_r;
      S_CHECK: cmd.check = 1'b1;
      S_STORE: cmd.store = 1'b1;
      S_TEST:  cmd.test = 1'b1;
      S_RD_L: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = NB_LEFT;
      end
      S_RD_R: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = NB_RIGHT;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = NB_LEFT;
      end
      S_RD_U: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = NB_UP;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = NB_RIGHT;
      end
      S_RD_D: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = NB_DOWN;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = NB_UP;
      end
      S_CAP_D: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = NB_DOWN;
      end
      S_MAG:   cmd.mag = 1'b1;
      S_MUL_A: cmd.mul_a = 1'b1;
      S_MUL_B: cmd.mul_b = 1'b1;
      S_SQ_A:  cmd.sq_a = 1'b1;
      S_SQ_B:  cmd.sq_b = 1'b1;
      S_ACC:   cmd.acc = 1'b1;
      S_SQRT:  cmd.sqrt_step = !st.sqrt_done;
      S_DIV_X0: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_X;
      end
      S_DIV_X:  cmd.div_step = !st.div_done;
      S_DIV_Y0: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_Y;
      end
      S_DIV_Y:  cmd.div_step = !st.div_done;
      S_EMIT:   cmd.emit = st.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// File: rtl/hnm_dp.sv
// Datapath: counters, line store, neighbour fetch, square root, dividers, output register.
module hnm_dp #(
  parameter int MAX_WIDTH  = hnm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hnm_pkg::DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hnm_pkg::cfg_t     cfg,
  input  hnm_pkg::in_t      in_data,
  input  hnm_pkg::dp_cmd_t  cmd,
  output hnm_pkg::dp_stat_t st,
  output logic              out_valid,
  input  logic              out_ready,
  output hnm_pkg::out_t     out_data
);
  import hnm_pkg::*;

  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int CNT_W = W_W + H_W;
  localparam int DEPTH = 2 * MAX_WIDTH + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int CWW   = (GEO_W > W_W) ? GEO_W : W_W;
  localparam int CWH   = (GEO_W > H_W) ? GEO_W : H_W;

  function automatic logic [7:0] sat_q(input logic [QUO_W-1:0] q);
    return (q > QUO_W'(255)) ? 8'hFF : q[7:0];
  endfunction

  // geometry
  logic [CWW-1:0]   wcfg;
  logic [CWH-1:0]   hcfg;
  logic [W_W-1:0]   w_eff;
  logic [H_W-1:0]   h_eff;
  logic [CNT_W-1:0] size_r;

  always_comb begin
    wcfg = CWW'(cfg.image_width);
    hcfg = CWH'(cfg.image_height);
    if (wcfg == '0) w_eff = W_W'(1);
    else if (wcfg > CWW'(MAX_WIDTH)) w_eff = W_W'(MAX_WIDTH);
    else w_eff = W_W'(wcfg);
    if (hcfg == '0) h_eff = H_W'(1);
    else if (hcfg > CWH'(MAX_HEIGHT)) h_eff = H_W'(MAX_HEIGHT);
    else h_eff = H_W'(hcfg);
  end

  always_ff @(posedge clk) begin
    size_r <= CNT_W'(w_eff) * CNT_W'(h_eff);
  end

  // item capture
  logic             cmd_r;
  logic [SMP_W-1:0] sample_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r    <= in_data.cmd;
      sample_r <= in_data.sample;
    end
  end

  // counters and ring pointers
  logic [CNT_W-1:0] rec_r, em_r;
  logic [AW-1:0]    wptr_r, eptr_r;
  logic             store_ok, em_last, stale;
  logic [CNT_W:0]   em_x, rec_x, size_x, em_p1, em_pw, dn_idx, rt_idx;

  always_comb begin
    em_x     = {1'b0, em_r};
    rec_x    = {1'b0, rec_r};
    size_x   = {1'b0, size_r};
    em_p1    = em_x + (CNT_W+1)'(1);
    em_pw    = em_x + (CNT_W+1)'(w_eff);
    stale    = (em_r >= size_r) || (rec_r > size_r);
    store_ok = (cmd_r == CMD_SAMPLE) && (rec_r < size_r) &&
               ((rec_r - em_r) <= CNT_W'(MAX_WIDTH));
    em_last  = em_p1 >= size_x;
    dn_idx   = (em_pw < size_x) ? em_pw : em_x;
    rt_idx   = (em_p1 < size_x) ? em_p1 : em_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r  <= '0;
      em_r   <= '0;
      wptr_r <= '0;
      eptr_r <= '0;
    end else if (cmd.check && stale) begin
      rec_r  <= '0;
      em_r   <= '0;
      wptr_r <= '0;
      eptr_r <= '0;
    end else if (cmd.store && store_ok) begin
      rec_r  <= rec_r + CNT_W'(1);
      wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end else if (cmd.emit) begin
      if (em_last) begin
        rec_r  <= '0;
        em_r   <= '0;
        wptr_r <= '0;
        eptr_r <= '0;
      end else begin
        em_r   <= em_r + CNT_W'(1);
        eptr_r <= (eptr_r == AW'(DEPTH - 1)) ? '0 : eptr_r + AW'(1);
      end
    end
  end

  // neighbour addresses
  logic [AW:0]   ep_x, w_a, dn_s, up_w, dn_w;
  logic [AW-1:0] lf_w, rt_w;
  logic [AW-1:0] lf_a_r, rt_a_r, up_a_r, dn_a_r;

  always_comb begin
    ep_x = {1'b0, eptr_r};
    w_a  = (AW+1)'(w_eff);
    up_w = (ep_x >= w_a) ? ep_x - w_a : ep_x + (AW+1)'(DEPTH) - w_a;
    dn_s = ep_x + w_a;
    dn_w = (dn_s >= (AW+1)'(DEPTH)) ? dn_s - (AW+1)'(DEPTH) : dn_s;
    lf_w = (eptr_r == '0) ? AW'(DEPTH - 1) : eptr_r - AW'(1);
    rt_w = (eptr_r == AW'(DEPTH - 1)) ? '0 : eptr_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.test) begin
      up_a_r <= (em_r >= CNT_W'(w_eff)) ? up_w[AW-1:0] : eptr_r;
      dn_a_r <= (em_pw < size_x) ? dn_w[AW-1:0] : eptr_r;
      lf_a_r <= (em_r != '0) ? lf_w : eptr_r;
      rt_a_r <= (em_p1 < size_x) ? rt_w : eptr_r;
    end
  end

  // line store
  logic [AW-1:0]    raddr;
  logic [SMP_W-1:0] rdata, smp;

  always_comb begin
    unique case (cmd.rd_sel)
      NB_LEFT:  raddr = lf_a_r;
      NB_RIGHT: raddr = rt_a_r;
      NB_UP:    raddr = up_a_r;
      NB_DOWN:  raddr = dn_a_r;
      default:  raddr = lf_a_r;
    endcase
  end

  hnm_ram #(
    .WIDTH (SMP_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (cmd.store && store_ok),
    .waddr (wptr_r),
    .wdata (sample_r),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign smp = cfg.wide_samples ? rdata : {8'h00, rdata[7:0]};

  logic [SMP_W-1:0] l_r, r_r, u_r, d_r, ad_a_r, ad_b_r;
  logic             na_r, nb_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        NB_LEFT:  l_r <= smp;
        NB_RIGHT: r_r <= smp;
        NB_UP:    u_r <= smp;
        NB_DOWN:  d_r <= smp;
        default:  l_r <= smp;
      endcase
    end
    if (cmd.mag) begin
      na_r   <= l_r < r_r;
      ad_a_r <= (l_r < r_r) ? r_r - l_r : l_r - r_r;
      nb_r   <= u_r < d_r;
      ad_b_r <= (u_r < d_r) ? d_r - u_r : u_r - d_r;
    end
  end

  // magnitudes, sum of squares and square root
  logic [MAG_W-1:0]  ma_r, mb_r;
  logic [PROD_W-1:0] prod_r;
  logic [RAD_W-1:0]  acc_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] res_r;
  logic [5:0]        scnt_r;
  logic [REM_W+1:0]  rtmp, trial;

  always_comb begin
    rtmp  = {rem_r, acc_r[RAD_W-1 -: 2]};
    trial = (REM_W+2)'({res_r, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_a) ma_r <= MAG_W'(ad_a_r) * MAG_W'(cfg.height_gain);
    if (cmd.mul_b) mb_r <= MAG_W'(ad_b_r) * MAG_W'(cfg.height_gain);
    if (cmd.sq_a) prod_r <= ma_r * ma_r;
    if (cmd.sq_b) begin
      acc_r  <= RAD_W'(prod_r) + (cfg.wide_samples ? CSQ_WIDE : CSQ_NARROW);
      prod_r <= mb_r * mb_r;
    end
    if (cmd.acc) begin
      acc_r <= acc_r + RAD_W'(prod_r);
      rem_r <= '0;
      res_r <= '0;
    end else if (cmd.sqrt_step) begin
      acc_r <= {acc_r[RAD_W-3:0], 2'b00};
      if (rtmp >= trial) begin
        rem_r <= REM_W'(rtmp - trial);
        res_r <= {res_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r <= REM_W'(rtmp);
        res_r <= {res_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // restoring divider, shared by both components
  logic [MAG_W-1:0] mag_sel;
  logic             neg_sel;
  logic [NUM_W-1:0] num;
  logic [DVD_W-1:0] drem_r, dsh_r;
  logic [QUO_W-1:0] quo_r;
  logic [3:0]       dcnt_r;
  logic [7:0]       qx_r;

  always_comb begin
    mag_sel = (cmd.div_sel == SEL_Y) ? mb_r : ma_r;
    neg_sel = (cmd.div_sel == SEL_Y) ? nb_r : na_r;
    num     = neg_sel ? NUM_W'(res_r) - NUM_W'(mag_sel) : NUM_W'(res_r) + NUM_W'(mag_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scnt_r <= '0;
      dcnt_r <= '0;
    end else begin
      if (cmd.acc) scnt_r <= 6'(SQRT_STEPS);
      else if (cmd.sqrt_step) scnt_r <= scnt_r - 6'd1;
      if (cmd.div_start) dcnt_r <= 4'(DIV_STEPS);
      else if (cmd.div_step) dcnt_r <= dcnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      drem_r <= (DVD_W'(num) << 8) - DVD_W'(num);
      dsh_r  <= DVD_W'({res_r, 1'b0}) << 8;
      quo_r  <= '0;
      if (cmd.div_sel == SEL_Y) qx_r <= sat_q(quo_r);
    end else if (cmd.div_step) begin
      dsh_r <= dsh_r >> 1;
      if (drem_r >= dsh_r) begin
        drem_r <= drem_r - dsh_r;
        quo_r  <= {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        quo_r  <= {quo_r[QUO_W-2:0], 1'b0};
      end
    end
  end

  // output register
  logic out_valid_r;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.normal_x   <= qx_r;
      out_data_r.normal_y   <= sat_q(quo_r);
      out_data_r.last_pixel <= em_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign st.emit_ok   = (em_x < rec_x) && (rt_idx < rec_x) && (dn_idx < rec_x);
  assign st.sqrt_done = scnt_r == '0;
  assign st.div_done  = dcnt_r == '0;
  assign st.out_free  = !out_valid_r || out_ready;

endmodule

// File: rtl/heightmap_to_normal_map.sv
// Top level: heightmap to two-byte normal map, with register file and checks.
//
// Channel | Ports                       | Beat
// input   | in_valid/in_ready/in_data   | one height sample or drain step
// result  | out_valid/out_ready/out_data| one pixel normal
// config  | cfg_p* (APB-style)          | one register write or read
//
// An item with no result passes through the idle, check, store and test states; one
// that yields a normal also runs the 33-step square root and two 9-step divisions on
// one shared divider, plus four reads through the single line store read port.
// Reset is synchronous, active low; the line store is not cleared.
// A finished result waits in the output register while the next item is taken.
module heightmap_to_normal_map #(
  parameter int MAX_WIDTH  = hnm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hnm_pkg::DEF_MAX_HEIGHT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hnm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output hnm_pkg::out_t out_data,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [3:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);
  import hnm_pkg::*;

  cfg_t     cfg_r;
  dp_cmd_t  ctl_cmd;
  dp_stat_t dp_st;
  logic     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= GEO_W'(256);
      cfg_r.image_height <= GEO_W'(256);
      cfg_r.height_gain  <= GAIN_W'(1);
      cfg_r.wide_samples <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_WIDTH:  cfg_r.image_width  <= cfg_pwdata[GEO_W-1:0];
        REG_HEIGHT: cfg_r.image_height <= cfg_pwdata[GEO_W-1:0];
        REG_GAIN:   cfg_r.height_gain  <= cfg_pwdata[GAIN_W-1:0];
        REG_WIDE:   cfg_r.wide_samples <= cfg_pwdata[0];
        default:    cfg_r.wide_samples <= cfg_r.wide_samples;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_WIDTH:  cfg_prdata = 32'(cfg_r.image_width);
      REG_HEIGHT: cfg_prdata = 32'(cfg_r.image_height);
      REG_GAIN:   cfg_prdata = 32'(cfg_r.height_gain);
      REG_WIDE:   cfg_prdata = 32'(cfg_r.wide_samples);
      default:    cfg_prdata = '0;
    endcase
  end

  hnm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (dp_st),
    .cmd      (ctl_cmd)
  );

  hnm_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (ctl_cmd),
    .st        (dp_st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.emit |-> dp_st.out_free)
    else $error("result loaded over a pending beat");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready held after accept");

  a_div_after_root: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.div_start |-> dp_st.sqrt_done)
    else $error("divide started before square root finished");

endmodule

// File: tb/heightmap_to_normal_map_tb.sv
// Testbench for heightmap_to_normal_map: scoreboard with a normal predictor, directed and random traffic.
`timescale 1ns / 100ps

module heightmap_to_normal_map_tb;
  import hnm_pkg::*;

  localparam int STORE_N   = 2 * DEF_MAX_WIDTH + 2;
  localparam int WDOG_MAX  = 20000;
  localparam int SETTLE    = 100;

  class normal_scoreboard;
    bit [15:0] heights [STORE_N];
    int unsigned rx_cnt, tx_cnt;
    int unsigned geo_w, geo_h, gain;
    bit wide;
    out_t expected_normals[$];
    int errors;

    function void reset_state();
      rx_cnt = 0; tx_cnt = 0;
      geo_w = 256; geo_h = 256; gain = 1; wide = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_WIDTH:  geo_w = 32'(val[12:0]);
        REG_HEIGHT: geo_h = 32'(val[12:0]);
        REG_GAIN:   gain  = 32'(val[15:0]);
        REG_WIDE:   wide  = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_w();
      eff_w = geo_w == 0 ? 1 : (geo_w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : geo_w);
    endfunction

    function int unsigned eff_size();
      int unsigned h;
      h = geo_h == 0 ? 1 : (geo_h > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : geo_h);
      eff_size = eff_w() * h;
    endfunction

    function bit [15:0] height_at(int unsigned p);
      bit [15:0] v;
      v = heights[p % STORE_N];
      height_at = wide ? v : {8'd0, v[7:0]};
    endfunction

    function bit [63:0] isqrt(bit [127:0] v);
      bit [63:0] r, c;
      r = 0;
      for (int b = 35; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ({64'd0, c} * {64'd0, c} <= v) r = c;
      end
      isqrt = r;
    endfunction

    function bit [7:0] component(bit [63:0] mag, bit neg, bit [63:0] len);
      bit [127:0] num, q;
      num = neg ? len - mag : len + mag;
      q = (128'd255 * num) / (128'd2 * len);
      component = q > 255 ? 8'd255 : q[7:0];
    endfunction

    function void note_sample(in_t it);
      int unsigned w, size, e, up, dn, lf, rt;
      bit [15:0] lv, rv, uv, dv;
      bit na, nb;
      bit [63:0] ma, mb, c, len;
      bit [127:0] rad;
      out_t r;
      w = eff_w();
      size = eff_size();
      if (tx_cnt >= size || rx_cnt > size) begin
        tx_cnt = 0; rx_cnt = 0;
      end
      if (it.cmd == CMD_SAMPLE && rx_cnt < size && rx_cnt - tx_cnt <= DEF_MAX_WIDTH) begin
        heights[rx_cnt % STORE_N] = it.sample;
        rx_cnt++;
      end
      e = tx_cnt;
      if (e >= rx_cnt) return;
      up = e >= w ? e - w : e;
      dn = e + w <= size - 1 ? e + w : e;
      lf = e > 0 ? e - 1 : e;
      rt = e + 1 <= size - 1 ? e + 1 : e;
      if (rt >= rx_cnt || dn >= rx_cnt) return;
      lv = height_at(lf); rv = height_at(rt);
      uv = height_at(up); dv = height_at(dn);
      na = lv < rv;
      ma = 64'(na ? rv - lv : lv - rv) * gain;
      nb = uv < dv;
      mb = 64'(nb ? dv - uv : uv - dv) * gain;
      c = wide ? 64'd131070 : 64'd510;
      rad = {64'd0, ma} * ma + {64'd0, mb} * mb + {64'd0, c} * c;
      len = isqrt(rad);
      r.normal_x = component(ma, na, len);
      r.normal_y = component(mb, nb, len);
      r.last_pixel = e == size - 1;
      expected_normals.push_back(r);
      tx_cnt = e + 1;
      if (tx_cnt >= size) begin
        tx_cnt = 0; rx_cnt = 0;
      end
    endfunction

    function void check_normal(out_t got);
      out_t exp_r;
      if (expected_normals.size() == 0) begin
        $display("%0t: unexpected beat x=%0d y=%0d last=%0b", $time,
                 got.normal_x, got.normal_y, got.last_pixel);
        errors++;
        return;
      end
      exp_r = expected_normals.pop_front();
      if (got.normal_x !== exp_r.normal_x) begin
        $display("%0t: normal_x exp %0d got %0d", $time, exp_r.normal_x, got.normal_x);
        errors++;
      end
      if (got.normal_y !== exp_r.normal_y) begin
        $display("%0t: normal_y exp %0d got %0d", $time, exp_r.normal_y, got.normal_y);
        errors++;
      end
      if (got.last_pixel !== exp_r.last_pixel) begin
        $display("%0t: last_pixel exp %0b got %0b", $time, exp_r.last_pixel, got.last_pixel);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  in_t         in_data;
  out_t        out_data;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  normal_scoreboard sb;
  bit   idle_on;
  int   stall_left;
  int   wdog;

  heightmap_to_normal_map u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function int gap_len();
    int r;
    r = $urandom_range(99);
    if (!idle_on || r < 60) gap_len = 0;
    else if (r < 92) gap_len = $urandom_range(3, 1);
    else gap_len = $urandom_range(40, 5);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = gap_len();
      out_ready <= stall_left == 0;
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_normal(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) wdog <= 0;
    else if (wdog >= WDOG_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end else wdog <= wdog + 1;
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic configure(int w, int h, int g, bit wd);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_GAIN, g);
    reg_write(REG_WIDE, 32'(wd));
  endtask

  // drives one beat from a falling edge until accepted
  task automatic send(logic cmd, logic [15:0] smp);
    int g;
    in_t it;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    it.cmd = cmd; it.sample = smp;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(it);
    @(negedge clk);
  endtask

  task automatic send_random(int drain_pct);
    send($urandom_range(99) < drain_pct ? CMD_DRAIN : CMD_SAMPLE, 16'($urandom));
  endtask

  // stops driving and waits until every expected beat has left the block
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_normals.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // completes the current image, then waits for the block to go idle
  task automatic finish_image();
    while (sb.rx_cnt != 0) begin
      if (sb.rx_cnt < sb.eff_size()) send(CMD_SAMPLE, 16'($urandom));
      else send(CMD_DRAIN, 16'($urandom));
    end
    wait_idle();
  endtask

  initial begin
    int w, h, g;
    sb = new();
    sb.reset_state();
    idle_on = 1;
    rst_n = 0;
    in_valid = 0; in_data = '0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes, drains with nothing ready, excess samples
    configure(3, 3, 1, 0);
    send(CMD_DRAIN, 16'hFFFF);
    send(CMD_SAMPLE, 16'h0000);
    send(CMD_SAMPLE, 16'h00FF);
    send(CMD_SAMPLE, 16'hFF00);
    send(CMD_SAMPLE, 16'hFFFF);
    send(CMD_SAMPLE, 16'h0000);
    send(CMD_SAMPLE, 16'h00FF);
    send(CMD_SAMPLE, 16'h0000);
    send(CMD_SAMPLE, 16'h00FF);
    send(CMD_SAMPLE, 16'h0000);
    send(CMD_SAMPLE, 16'h1234);
    send(CMD_DRAIN, 16'h0000);
    finish_image();
    configure(2, 2, 65535, 1);
    send(CMD_SAMPLE, 16'h0000);
    send(CMD_SAMPLE, 16'hFFFF);
    send(CMD_SAMPLE, 16'hFFFF);
    send(CMD_SAMPLE, 16'h0000);
    finish_image();
    configure(1, 1, 0, 1);
    send(CMD_SAMPLE, 16'hABCD);
    send(CMD_DRAIN, 16'h0000);
    finish_image();

    // random phases, small geometry
    for (int p = 0; p < 14; p++) begin
      idle_on = p % 4 != 3;
      w = $urandom_range(9, 1);
      h = $urandom_range(6, 1);
      case ($urandom_range(3))
        0: g = 1;
        1: g = 65535;
        default: g = $urandom_range(65535, 1);
      endcase
      if (p == 5) begin w = 0; h = 0; end
      configure(w, h, g, 1'($urandom_range(1)));
      repeat (24) send_random(12);
      finish_image();
    end

    // oversize width saturates, zero height acts as one row; the second
    // setting keeps the same pixel count, so the image carries on
    idle_on = 1;
    configure(8191, 0, 300, 1);
    repeat (50) send_random(3);
    wait_idle();
    configure(4096, 1, 1, 0);
    repeat (50) send_random(10);
    wait_idle();

    if (sb.errors == 0 && sb.expected_normals.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
